// ===== hdl/btmx_pkg.sv =====
// Shared constants, state type and control structs for the min-XOR pair block.
package btmx_pkg;

    localparam int VALUE_W      = 30;   // input value and mask width
    localparam int KB_W         = 5;    // key_bits register and level counter width
    localparam int MAX_KEY_BITS = 30;   // widest trie key
    localparam int IDX_OUT_W    = 10;   // index width on the result beat

    typedef enum logic [2:0] {
        WK_IDLE,
        WK_WALK,
        WK_LEAF,
        WK_CHECK,
        WK_HEAD,
        WK_CHAIN,
        WK_DONE
    } t_walk_state;

    typedef struct packed {
        logic start;      // launch a walk for the latched value
        logic clear;      // empty the trie before this value
    } t_walk_cmd;

    typedef struct packed {
        logic done;       // one-cycle pulse, all results valid
        logic looked_up;  // a lookup was made, partner and leaf are valid
        logic node_ovf;   // insert skipped, node pool too small
    } t_walk_rsp;

endpackage

// ===== hdl/btmx_node_ram.sv =====
// Trie node memory: one write port, one registered read port.
module btmx_node_ram #(
    parameter int DEPTH = 32768,
    parameter int WIDTH = 42
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/btmx_walker.sv =====
// Trie walker: lookup walk, insert point capture and node insertion over the node memory.
module btmx_walker #(
    parameter int MAX_ITEMS  = 1024,
    parameter int NODE_COUNT = 32768
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  btmx_pkg::t_walk_cmd               i_cmd,
    input  logic [btmx_pkg::VALUE_W-1:0]      i_value,
    input  logic [btmx_pkg::KB_W-1:0]         i_key_bits,
    input  logic [$clog2(MAX_ITEMS)-1:0]      i_idx,
    output btmx_pkg::t_walk_rsp               o_rsp,
    output logic [btmx_pkg::VALUE_W-1:0]      o_partner,
    output logic [$clog2(MAX_ITEMS)-1:0]      o_leaf
);
    import btmx_pkg::*;

    localparam int IDX_W   = $clog2(MAX_ITEMS);
    localparam int NODE_W  = $clog2(NODE_COUNT);
    localparam int NC_W    = $clog2(NODE_COUNT + 1);
    localparam int ENTRY_W = 2 + 2 * NODE_W + IDX_W;

    // entry layout, low to high: leaf index, child zero, child one, valid bits
    t_walk_state r_state, n_state;

    logic                 mem_we, mem_re;
    logic [NODE_W-1:0]    mem_waddr, mem_raddr;
    logic [ENTRY_W-1:0]   mem_wdata, mem_rdata;

    logic [VALUE_W-1:0]   r_v, n_v;
    logic [KB_W-1:0]      r_lvl, n_lvl;
    logic [NODE_W-1:0]    r_u, n_u;
    logic                 r_at_root, n_at_root;
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic [VALUE_W-1:0]   r_partner, n_partner;
    logic [IDX_W-1:0]     r_leaf, n_leaf;
    logic                 r_looked_up, n_looked_up;
    logic                 r_node_ovf, n_node_ovf;
    logic [NC_W-1:0]      r_node_count, n_node_count;
    logic [1:0]           r_root_valid, n_root_valid;

    logic                 r_ins_found, n_ins_found;
    logic                 r_ins_root, n_ins_root;
    logic [NODE_W-1:0]    r_ins_node, n_ins_node;
    logic [KB_W-1:0]      r_ins_lvl, n_ins_lvl;
    logic [1:0]           r_ins_valid, n_ins_valid;
    logic [NODE_W-1:0]    r_ins_c0, n_ins_c0;
    logic [NODE_W-1:0]    r_ins_c1, n_ins_c1;
    logic [IDX_W-1:0]     r_ins_leaf, n_ins_leaf;

    logic [IDX_W-1:0]     rd_leaf;
    logic [NODE_W-1:0]    rd_c0, rd_c1;
    logic [1:0]           rd_valid, cur_valid;
    logic                 bit_v, has_match, has_other, take_bit, can_move;
    logic [NODE_W-1:0]    next_u;
    logic                 start_lookup;
    logic [KB_W-1:0]      need, lvl_m1;
    logic [NC_W-1:0]      room;
    logic                 pool_short;
    logic                 head_bit, chain_bit;
    logic [NODE_W-1:0]    nc_ptr, nxt_ptr;

    btmx_node_ram #(
        .DEPTH (NODE_COUNT),
        .WIDTH (ENTRY_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign rd_leaf  = mem_rdata[IDX_W-1:0];
    assign rd_c0    = mem_rdata[IDX_W +: NODE_W];
    assign rd_c1    = mem_rdata[IDX_W + NODE_W +: NODE_W];
    assign rd_valid = mem_rdata[ENTRY_W-1 -: 2];

    // root valid bits live in flops so a set clear is immediate
    assign cur_valid = r_at_root ? r_root_valid : rd_valid;
    assign bit_v     = r_v[r_lvl];
    assign has_match = cur_valid[bit_v];
    assign has_other = cur_valid[~bit_v];
    assign take_bit  = has_match ? bit_v : ~bit_v;
    assign can_move  = has_match | has_other;
    assign next_u    = take_bit ? rd_c1 : rd_c0;

    assign start_lookup = ~i_cmd.clear & (r_root_valid != 2'b00);

    assign need       = r_ins_found ? (r_ins_lvl + KB_W'(1)) : '0;
    assign room       = NC_W'(NODE_COUNT) - r_node_count;
    assign pool_short = NC_W'(need) > room;

    assign lvl_m1    = r_lvl - KB_W'(1);
    assign head_bit  = r_v[r_ins_lvl];
    assign chain_bit = r_v[lvl_m1];
    assign nc_ptr    = NODE_W'(r_node_count);
    assign nxt_ptr   = NODE_W'(r_node_count + NC_W'(1));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            WK_IDLE: begin
                if (i_cmd.start) begin
                    n_state = start_lookup ? WK_WALK : WK_CHECK;
                end
            end
            WK_WALK: begin
                if (!can_move || r_lvl == '0) begin
                    n_state = WK_LEAF;
                end
            end
            WK_LEAF:  n_state = WK_CHECK;
            WK_CHECK: begin
                if (!r_ins_found || pool_short) begin
                    n_state = WK_DONE;
                end else begin
                    n_state = WK_HEAD;
                end
            end
            WK_HEAD:  n_state = WK_CHAIN;
            WK_CHAIN: begin
                if (r_lvl == '0) begin
                    n_state = WK_DONE;
                end
            end
            WK_DONE:  n_state = WK_IDLE;
            default:  n_state = WK_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_v          = r_v;
        n_lvl        = r_lvl;
        n_u          = r_u;
        n_at_root    = r_at_root;
        n_idx        = r_idx;
        n_partner    = r_partner;
        n_leaf       = r_leaf;
        n_looked_up  = r_looked_up;
        n_node_ovf   = r_node_ovf;
        n_node_count = r_node_count;
        n_root_valid = r_root_valid;
        n_ins_found  = r_ins_found;
        n_ins_root   = r_ins_root;
        n_ins_node   = r_ins_node;
        n_ins_lvl    = r_ins_lvl;
        n_ins_valid  = r_ins_valid;
        n_ins_c0     = r_ins_c0;
        n_ins_c1     = r_ins_c1;
        n_ins_leaf   = r_ins_leaf;
        mem_re       = 1'b0;
        mem_raddr    = r_u;
        mem_we       = 1'b0;
        mem_waddr    = nc_ptr;
        mem_wdata    = '0;
        case (r_state)
            WK_IDLE: begin
                if (i_cmd.start) begin
                    n_v         = i_value;
                    n_idx       = i_idx;
                    n_lvl       = i_key_bits - KB_W'(1);
                    n_u         = '0;
                    n_at_root   = 1'b1;
                    n_partner   = '0;
                    n_looked_up = 1'b0;
                    n_node_ovf  = 1'b0;
                    if (i_cmd.clear) begin
                        n_node_count = NC_W'(1);
                        n_root_valid = 2'b00;
                    end
                    if (start_lookup) begin
                        n_ins_found = 1'b0;
                        mem_re      = 1'b1;
                        mem_raddr   = '0;
                    end else begin
                        // empty trie: insert straight from the root
                        n_ins_found = 1'b1;
                        n_ins_root  = 1'b1;
                        n_ins_node  = '0;
                        n_ins_lvl   = i_key_bits - KB_W'(1);
                        n_ins_valid = 2'b00;
                        n_ins_c0    = '0;
                        n_ins_c1    = '0;
                        n_ins_leaf  = '0;
                    end
                end
            end
            WK_WALK: begin
                if (!has_match && !r_ins_found) begin
                    // first level off the value's own path: insert starts here
                    n_ins_found = 1'b1;
                    n_ins_root  = r_at_root;
                    n_ins_node  = r_u;
                    n_ins_lvl   = r_lvl;
                    n_ins_valid = cur_valid;
                    n_ins_c0    = rd_c0;
                    n_ins_c1    = rd_c1;
                    n_ins_leaf  = rd_leaf;
                end
                mem_re = 1'b1;
                if (can_move) begin
                    n_partner[r_lvl] = take_bit;
                    n_u              = next_u;
                    n_at_root        = 1'b0;
                    mem_raddr        = next_u;
                    if (r_lvl != '0) begin
                        n_lvl = lvl_m1;
                    end
                end else begin
                    // dead end: re-read this node for its leaf index
                    mem_raddr = r_u;
                end
            end
            WK_LEAF: begin
                n_leaf      = rd_leaf;
                n_looked_up = 1'b1;
            end
            WK_CHECK: begin
                if (r_ins_found && pool_short) begin
                    n_node_ovf = 1'b1;
                end
            end
            WK_HEAD: begin
                mem_we    = 1'b1;
                mem_waddr = r_ins_node;
                mem_wdata = {r_ins_valid | (head_bit ? 2'b10 : 2'b01),
                             head_bit ? nc_ptr : r_ins_c1,
                             head_bit ? r_ins_c0 : nc_ptr,
                             r_ins_leaf};
                if (r_ins_root) begin
                    n_root_valid = r_root_valid | (head_bit ? 2'b10 : 2'b01);
                end
                n_lvl = r_ins_lvl;
            end
            WK_CHAIN: begin
                mem_we    = 1'b1;
                mem_waddr = nc_ptr;
                if (r_lvl == '0) begin
                    mem_wdata = {2'b00, {NODE_W{1'b0}}, {NODE_W{1'b0}}, r_idx};
                end else begin
                    mem_wdata = {chain_bit ? 2'b10 : 2'b01,
                                 chain_bit ? nxt_ptr : {NODE_W{1'b0}},
                                 chain_bit ? {NODE_W{1'b0}} : nxt_ptr,
                                 r_idx};
                    n_lvl = lvl_m1;
                end
                n_node_count = r_node_count + NC_W'(1);
            end
            WK_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= WK_IDLE;
            r_node_count <= NC_W'(1);
            r_root_valid <= 2'b00;
            r_looked_up  <= 1'b0;
            r_node_ovf   <= 1'b0;
            r_ins_found  <= 1'b0;
            r_at_root    <= 1'b1;
        end else begin
            r_state      <= n_state;
            r_node_count <= n_node_count;
            r_root_valid <= n_root_valid;
            r_looked_up  <= n_looked_up;
            r_node_ovf   <= n_node_ovf;
            r_ins_found  <= n_ins_found;
            r_at_root    <= n_at_root;
        end
    end

    always_ff @(posedge i_clk) begin
        r_v         <= n_v;
        r_lvl       <= n_lvl;
        r_u         <= n_u;
        r_idx       <= n_idx;
        r_partner   <= n_partner;
        r_leaf      <= n_leaf;
        r_ins_root  <= n_ins_root;
        r_ins_node  <= n_ins_node;
        r_ins_lvl   <= n_ins_lvl;
        r_ins_valid <= n_ins_valid;
        r_ins_c0    <= n_ins_c0;
        r_ins_c1    <= n_ins_c1;
        r_ins_leaf  <= n_ins_leaf;
    end

    assign o_rsp.done      = (r_state == WK_DONE);
    assign o_rsp.looked_up = r_looked_up;
    assign o_rsp.node_ovf  = r_node_ovf;
    assign o_partner       = r_partner;
    assign o_leaf          = r_leaf;

endmodule

// ===== hdl/binary_trie_min_xor_pair_core.sv =====
// Top level of the streaming minimum-XOR pair finder built on a binary trie.
//
//  channel   dir  handshake                     payload
//  --------  ---  ----------------------------  --------------------------------------
//  s_axis    in   s_axis_tvalid/s_axis_tready   tdata value, tuser first_of_set
//  m_axis    out  m_axis_tvalid/m_axis_tready   tdata indices and mask, tuser flags
//  cfg       in   i_cfg_valid/o_cfg_ready       i_cfg_data = key_bits
//
// An input beat makes one dependent node read per trie level of the effective key
// width on the lookup walk, then a head write plus one write per new node on the
// insert, with no writes when no node is added; a full item counter skips the walk.
// Reset is synchronous, active low; the trie needs no clearing pass since only
// the root valid bits are in flops. A stalled result sits in the output register
// while the next input beat is worked; the input stalls until that slot frees.
module binary_trie_min_xor_pair_core #(
    parameter int MAX_ITEMS  = 1024,
    parameter int NODE_COUNT = 32768
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [4:0]  i_cfg_data,      // key_bits
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,    // [29:0] value, [31:30] zero
    input  logic        s_axis_tuser,    // [0] first_of_set
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata,    // [9:0] first_index, [19:10] second_index,
                                         // [49:20] mask_x, [55:50] zero
    output logic [1:0]  m_axis_tuser     // [0] pair_found, [1] overflow
);
    import btmx_pkg::*;

    localparam int IDX_W = $clog2(MAX_ITEMS);
    localparam int CNT_W = $clog2(MAX_ITEMS + 1);

    logic [KB_W-1:0]    r_key_bits;
    logic [KB_W-1:0]    kb_eff;
    logic [VALUE_W-1:0] full_mask, value_masked;

    logic               accept;
    logic [CNT_W-1:0]   item_base;
    logic               cnt_full;

    logic               r_busy, r_pending;
    logic [CNT_W-1:0]   r_item_count;
    logic               r_ovf;
    logic               r_best_valid;
    logic [VALUE_W-1:0] r_best_score;
    logic [IDX_W-1:0]   r_best_first, r_best_second;
    logic [VALUE_W-1:0] r_best_mask;
    logic [VALUE_W-1:0] r_cur_v;
    logic [IDX_W-1:0]   r_cur_idx;

    logic               r_m_tvalid;
    logic [55:0]        r_m_tdata;
    logic [1:0]         r_m_tuser;
    logic               out_load;

    t_walk_cmd          walk_cmd;
    t_walk_rsp          walk_rsp;
    logic [VALUE_W-1:0] walk_partner;
    logic [IDX_W-1:0]   walk_leaf;

    logic [VALUE_W-1:0] score, pair_mask;
    logic               better;

    // key width clamped to 1..MAX_KEY_BITS
    always_comb begin
        if (r_key_bits == '0) begin
            kb_eff = KB_W'(1);
        end else if (r_key_bits > KB_W'(MAX_KEY_BITS)) begin
            kb_eff = KB_W'(MAX_KEY_BITS);
        end else begin
            kb_eff = r_key_bits;
        end
    end

    assign full_mask    = ~({VALUE_W{1'b1}} << kb_eff);
    assign value_masked = s_axis_tdata[VALUE_W-1:0] & full_mask;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = ~r_busy & ~r_pending;
    assign accept        = s_axis_tvalid & s_axis_tready;

    // item index for this beat, counting restarts on a new set
    assign item_base = s_axis_tuser ? '0 : r_item_count;
    assign cnt_full  = item_base >= CNT_W'(MAX_ITEMS);

    assign walk_cmd.start = accept & ~cnt_full;
    assign walk_cmd.clear = s_axis_tuser;

    btmx_walker #(
        .MAX_ITEMS  (MAX_ITEMS),
        .NODE_COUNT (NODE_COUNT)
    ) u_walker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (walk_cmd),
        .i_value    (value_masked),
        .i_key_bits (kb_eff),
        .i_idx      (IDX_W'(item_base)),
        .o_rsp      (walk_rsp),
        .o_partner  (walk_partner),
        .o_leaf     (walk_leaf)
    );

    // score is the complemented XOR inside the key; ties keep the older pair
    assign score     = full_mask & ~(walk_partner ^ r_cur_v);
    assign pair_mask = full_mask & ~(walk_partner | r_cur_v);
    assign better    = walk_rsp.looked_up & (~r_best_valid | (score > r_best_score));

    // result register: loads when a finished beat waits and the slot frees
    assign out_load = r_pending & (~r_m_tvalid | m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_bits    <= KB_W'(MAX_KEY_BITS);
            r_busy        <= 1'b0;
            r_pending     <= 1'b0;
            r_item_count  <= '0;
            r_ovf         <= 1'b0;
            r_best_valid  <= 1'b0;
            r_best_score  <= '0;
            r_best_first  <= '0;
            r_best_second <= '0;
            r_best_mask   <= '0;
            r_m_tvalid    <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_key_bits <= i_cfg_data;
            end

            if (accept) begin
                if (s_axis_tuser) begin
                    r_ovf         <= 1'b0;
                    r_best_valid  <= 1'b0;
                    r_best_score  <= '0;
                    r_best_first  <= '0;
                    r_best_second <= '0;
                    r_best_mask   <= '0;
                end
                if (cnt_full) begin
                    // item counter exhausted: report the running pair as is
                    r_item_count <= item_base;
                    r_ovf        <= 1'b1;
                    r_pending    <= 1'b1;
                end else begin
                    r_item_count <= item_base + CNT_W'(1);
                    r_busy       <= 1'b1;
                end
            end

            if (walk_rsp.done) begin
                r_busy    <= 1'b0;
                r_pending <= 1'b1;
                if (walk_rsp.node_ovf) begin
                    r_ovf <= 1'b1;
                end
                if (better) begin
                    r_best_valid  <= 1'b1;
                    r_best_score  <= score;
                    r_best_first  <= walk_leaf;
                    r_best_second <= r_cur_idx;
                    r_best_mask   <= pair_mask;
                end
            end

            if (out_load) begin
                r_pending  <= 1'b0;
                r_m_tvalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_tvalid <= 1'b0;
            end
        end
    end

    // per-beat payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (accept && !cnt_full) begin
            r_cur_v   <= value_masked;
            r_cur_idx <= IDX_W'(item_base);
        end
        if (out_load) begin
            r_m_tdata <= {6'b0, r_best_mask, IDX_OUT_W'(r_best_second),
                          IDX_OUT_W'(r_best_first)};
            r_m_tuser <= {r_ovf, r_best_valid};
        end
    end

    assign m_axis_tvalid = r_m_tvalid;
    assign m_axis_tdata  = r_m_tdata;
    assign m_axis_tuser  = r_m_tuser;

endmodule

// ===== bench/btmx_pair_tracker_pkg.sv =====
// Scoreboard for the min-XOR pair bench: trie predictor and queue of pending result beats.
package btmx_pair_tracker_pkg;
    import btmx_pkg::*;

    localparam int ITEM_LIMIT = 1024;
    localparam int NODE_POOL  = 32768;
    localparam int LINK_W     = $clog2(NODE_POOL);

    typedef struct packed {
        logic                 pair_found;
        logic [IDX_OUT_W-1:0] first_index;
        logic [IDX_OUT_W-1:0] second_index;
        logic [VALUE_W-1:0]   mask_x;
        logic                 overflow;
    } t_pair_result;

    class min_xor_tracker;
        bit [LINK_W-1:0]  zero_link  [NODE_POOL];
        bit [LINK_W-1:0]  one_link   [NODE_POOL];
        bit [1:0]         branch_ok  [NODE_POOL];
        int unsigned      first_seen [NODE_POOL];
        int unsigned      nodes_used;
        int unsigned      items_taken;
        longint           best_score;
        int unsigned      best_first;
        int unsigned      best_second;
        bit [VALUE_W-1:0] best_mask;
        bit               overflow;
        bit [KB_W-1:0]    key_bits;
        t_pair_result     pending_pairs [$];
        int unsigned      beats_checked;
        int unsigned      mismatches;

        function new();
            key_bits      = KB_W'(MAX_KEY_BITS);
            beats_checked = 0;
            mismatches    = 0;
            clear_set();
        endfunction

        function void clear_set();
            branch_ok[0]  = 2'b00;
            first_seen[0] = 0;
            nodes_used    = 1;
            items_taken   = 0;
            best_score    = -1;
            best_first    = 0;
            best_second   = 0;
            best_mask     = '0;
            overflow      = 1'b0;
        endfunction

        // register value 0 behaves as 1, anything above the widest key is clamped
        function int key_width();
            if (key_bits == 0) return 1;
            if (key_bits > MAX_KEY_BITS) return MAX_KEY_BITS;
            return int'(key_bits);
        endfunction

        // one accepted input beat: lookup, best-pair update, insert, queue the result
        function void take_value(logic [VALUE_W-1:0] value, logic first);
            int               kb;
            int               lvl;
            int unsigned      idx;
            int unsigned      u;
            int unsigned      need;
            int unsigned      n;
            bit               b;
            bit [VALUE_W-1:0] full;
            bit [VALUE_W-1:0] v;
            bit [VALUE_W-1:0] partner;
            longint           score;
            t_pair_result     want;

            kb   = key_width();
            full = VALUE_W'((64'd1 << kb) - 64'd1);
            v    = value & full;
            if (first) clear_set();

            if (items_taken >= ITEM_LIMIT) begin
                overflow = 1'b1;
            end else begin
                idx = items_taken;
                items_taken++;

                if (branch_ok[0] != 2'b00) begin
                    u       = 0;
                    partner = '0;
                    for (lvl = kb - 1; lvl >= 0; lvl--) begin
                        b = v[lvl];
                        if (!branch_ok[u][b]) begin
                            // node without children: walk ends early
                            if (!branch_ok[u][~b]) break;
                            b = ~b;
                        end
                        u = b ? one_link[u] : zero_link[u];
                        partner[lvl] = b;
                    end
                    score = longint'(full & ~(partner ^ v));
                    if (score > best_score) begin
                        best_score  = score;
                        best_first  = first_seen[u];
                        best_second = idx;
                        best_mask   = full & ~(partner | v);
                    end
                end

                u    = 0;
                need = 0;
                for (lvl = kb - 1; lvl >= 0; lvl--) begin
                    b = v[lvl];
                    if (!branch_ok[u][b]) begin
                        need = lvl + 1;
                        break;
                    end
                    u = b ? one_link[u] : zero_link[u];
                end
                if (need > NODE_POOL - nodes_used) begin
                    overflow = 1'b1;
                end else begin
                    u = 0;
                    for (lvl = kb - 1; lvl >= 0; lvl--) begin
                        b = v[lvl];
                        if (!branch_ok[u][b]) begin
                            n = nodes_used;
                            nodes_used++;
                            branch_ok[n]  = 2'b00;
                            first_seen[n] = idx;
                            if (b) one_link[u] = n;
                            else zero_link[u] = n;
                            branch_ok[u][b] = 1'b1;
                        end
                        u = b ? one_link[u] : zero_link[u];
                    end
                end
            end

            want.pair_found   = (best_score >= 0);
            want.first_index  = IDX_OUT_W'(best_first);
            want.second_index = IDX_OUT_W'(best_second);
            want.mask_x       = best_mask;
            want.overflow     = overflow;
            pending_pairs.push_back(want);
        endfunction

        task report_mismatch(string what);
            if (mismatches < 60) $display("%0t  mismatch: %s", $time, what);
            mismatches++;
        endtask

        task check_pair(t_pair_result got);
            t_pair_result want;
            if (pending_pairs.size() == 0) begin
                report_mismatch($sformatf("result beat %0d with nothing pending", beats_checked));
            end else begin
                want = pending_pairs.pop_front();
                if (got.pair_found !== want.pair_found)
                    report_mismatch($sformatf("beat %0d pair_found %b, want %b",
                        beats_checked, got.pair_found, want.pair_found));
                if (got.first_index !== want.first_index)
                    report_mismatch($sformatf("beat %0d first_index %0d, want %0d",
                        beats_checked, got.first_index, want.first_index));
                if (got.second_index !== want.second_index)
                    report_mismatch($sformatf("beat %0d second_index %0d, want %0d",
                        beats_checked, got.second_index, want.second_index));
                if (got.mask_x !== want.mask_x)
                    report_mismatch($sformatf("beat %0d mask_x %h, want %h",
                        beats_checked, got.mask_x, want.mask_x));
                if (got.overflow !== want.overflow)
                    report_mismatch($sformatf("beat %0d overflow %b, want %b",
                        beats_checked, got.overflow, want.overflow));
            end
            beats_checked++;
        endtask
    endclass

endpackage

// ===== bench/binary_trie_min_xor_pair_core_test.sv =====
// Bench for the min-XOR pair core: directed and random value streams checked beat by beat.
module binary_trie_min_xor_pair_core_test;
    import btmx_pkg::*;
    import btmx_pair_tracker_pkg::*;

    // Longest quiet stretch of a correct run is one 30-bit item plus a long source
    // gap and a long sink stall.
    localparam int QUIET_LIMIT   = 3000;
    localparam int SETTLE_CYCLES = 2 * MAX_KEY_BITS + 6 + 40;
    localparam int RANDOM_ITEMS  = 100;
    localparam int LONG_SET      = ITEM_LIMIT + 6;

    localparam logic [KB_W-1:0] WIDTH_EXTREMES [4] = '{5'd0, 5'd1, 5'd30, 5'd31};

    logic                i_clk         = 1'b0;
    logic                i_rst_n       = 1'b0;
    logic                i_cfg_valid   = 1'b0;
    logic [KB_W-1:0]     i_cfg_data    = '0;
    logic                s_axis_tvalid = 1'b0;
    logic [31:0]         s_axis_tdata  = '0;    // [29:0] value, [31:30] zero
    logic                s_axis_tuser  = 1'b0;  // [0] first_of_set
    logic                m_axis_tready = 1'b0;
    logic                o_cfg_ready;
    logic                s_axis_tready;
    logic                m_axis_tvalid;
    logic [55:0]         m_axis_tdata;          // [9:0] first, [19:10] second, [49:20] mask
    logic [1:0]          m_axis_tuser;          // [0] pair_found, [1] overflow

    min_xor_tracker      tracker;
    t_pair_result        seen_pair;
    logic [VALUE_W-1:0]  set_history [$];      // values of the open set, for near-miss keys
    bit                  calm        = 1'b0;   // phase with no gaps on either side
    int                  stall_left  = 0;
    int                  quiet_cycles = 0;
    int                  items_sent  = 0;

    binary_trie_min_xor_pair_core #(
        .MAX_ITEMS (ITEM_LIMIT),
        .NODE_COUNT(NODE_POOL)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_data   (i_cfg_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Mostly back to back, some short gaps, now and then a long one.
    function automatic int next_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Random keys lean toward values near earlier ones in the set, so the trie
    // walk runs deep and ties and exact repeats turn up often.
    function automatic logic [VALUE_W-1:0] pick_value(int kb);
        int                 r;
        logic [VALUE_W-1:0] v;
        r = $urandom_range(0, 99);
        if (r < 35 || set_history.size() == 0)
            v = VALUE_W'($urandom());
        else if (r < 65)
            v = set_history[$urandom_range(0, set_history.size() - 1)]
                ^ (VALUE_W'(1) << $urandom_range(0, kb - 1));
        else if (r < 80)
            v = set_history[$urandom_range(0, set_history.size() - 1)];
        else
            v = VALUE_W'($urandom_range(0, 15));
        set_history.push_back(v);
        if (set_history.size() > 64) void'(set_history.pop_front());
        return v;
    endfunction

    // One input beat; valid stays up across back-to-back beats.
    task automatic send_value(input logic [VALUE_W-1:0] value, input logic first);
        int gap;
        gap = next_gap();
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= 32'(value);
        s_axis_tuser  <= first;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        tracker.take_value(value, first);
        items_sent++;
    endtask

    // Source holds off until every pending result beat has been taken.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (tracker.pending_pairs.size() != 0);
    endtask

    // Key width changes only with the block idle; the open set is not touched.
    task automatic retune(input logic [KB_W-1:0] bits);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= bits;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        tracker.key_bits = bits;
        i_cfg_valid <= 1'b0;
    endtask

    // Result sink: check on each accepted beat, then pick next cycle's ready.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen_pair.pair_found   = m_axis_tuser[0];
            seen_pair.overflow     = m_axis_tuser[1];
            seen_pair.first_index  = m_axis_tdata[9:0];
            seen_pair.second_index = m_axis_tdata[19:10];
            seen_pair.mask_x       = m_axis_tdata[49:20];
            tracker.check_pair(seen_pair);
        end
        if (stall_left != 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else begin
            stall_left = next_gap();
            m_axis_tready <= (stall_left == 0);
        end
    end

    // Watchdog: any beat on any channel counts as progress.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("binary_trie_min_xor_pair_core_test: errors");
        $finish;
    end

    initial begin
        int              k;
        int              phase_len;
        int              random_start;
        bit              open_set;
        logic            first;
        logic [KB_W-1:0] bits;

        tracker = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed ---
        // full 30-bit keys from reset: all-zero / all-ones, alternating patterns,
        // a repeated value that must report its first occurrence
        send_value(30'h0000_0000, 1'b1);
        send_value(30'h3FFF_FFFF, 1'b0);
        send_value(30'h1555_5555, 1'b0);
        send_value(30'h2AAA_AAAA, 1'b0);
        send_value(30'h0000_0000, 1'b0);
        // new set in mid stream forgets the old pair
        send_value(30'h3FFF_FFFF, 1'b1);
        send_value(30'h3FFF_FFFE, 1'b0);
        send_value(30'h0000_0001, 1'b0);

        // width 0 acts as one bit; upper bits ignored
        retune(5'd0);
        send_value(30'h0000_0002, 1'b1);
        send_value(30'h0000_0003, 1'b0);
        send_value(30'h3FFF_FFFF, 1'b0);

        // width 31 clamps to 30
        retune(5'd31);
        send_value(30'h1234_5678, 1'b1);
        send_value(30'h1234_5679, 1'b0);

        // equal scores keep the earlier pair
        retune(5'd4);
        send_value(30'h0000_0004, 1'b1);
        send_value(30'h0000_0005, 1'b0);
        send_value(30'h0000_000C, 1'b0);
        send_value(30'h0000_000D, 1'b0);

        // narrow then widen inside the same set; the wider walk stops at a
        // node with no children
        retune(5'd2);
        send_value(30'h0000_0001, 1'b0);
        send_value(30'h0000_0003, 1'b0);
        retune(5'd8);
        send_value(30'h0000_00FF, 1'b0);
        send_value(30'h0000_000F, 1'b0);

        // --- item counter exhaustion ---
        // One set past the item limit at a narrow key. The node pool cannot run
        // out at these sizes: 1024 items of at most 30 new nodes each fit.
        retune(5'($urandom_range(1, 4)));
        calm = 1'b1;
        set_history.delete();
        for (k = 0; k < LONG_SET; k++)
            send_value(pick_value(tracker.key_width()), k == 0);

        // --- random phases ---
        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) < 3)
                bits = WIDTH_EXTREMES[$urandom_range(0, 3)];
            else
                bits = 5'($urandom_range(0, 31));
            retune(bits);
            calm      = ($urandom_range(0, 3) == 0);
            phase_len = $urandom_range(20, 100);
            open_set  = ($urandom_range(0, 4) != 0);   // else carry the set across the change
            for (k = 0; k < phase_len; k++) begin
                first = (k == 0 && open_set) || ($urandom_range(0, 14) == 0);
                if (first) set_history.delete();
                send_value(pick_value(tracker.key_width()), first);
                if ($urandom_range(0, 49) == 0) drain_results();
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (tracker.pending_pairs.size() != 0)
            tracker.report_mismatch($sformatf("%0d results never delivered",
                tracker.pending_pairs.size()));
        if (tracker.mismatches == 0)
            $display("binary_trie_min_xor_pair_core_test: clean");
        else
            $display("binary_trie_min_xor_pair_core_test: errors");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/btmx_pkg.sv
hdl/btmx_node_ram.sv
hdl/btmx_walker.sv
hdl/binary_trie_min_xor_pair_core.sv
bench/btmx_pair_tracker_pkg.sv
bench/binary_trie_min_xor_pair_core_test.sv
